// ===== rtl/core/mhpq_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and codes for the min-heap priority queue core.
// -----------------------------------------------------------------------------

package mhpq_pkg;

    localparam int CAPACITY_DEF = 128;
    localparam int DATA_W       = 32;
    localparam int COUNT_W      = 8;

    // action codes
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic signed [DATA_W-1:0] NONE_VALUE = -32'sd1;

    typedef struct packed {
        logic                     action;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] popped_value;
        logic [1:0]               status;
        logic signed [DATA_W-1:0] top_value;
        logic [COUNT_W-1:0]       count;
    } t_out_item;

endpackage

// ===== rtl/core/min_heap_priority_queue_core.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// min_heap_priority_queue_core
// Binary min-heap of signed 32-bit values kept in a synchronous RAM.
// -----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one push or
//   pop per transfer. Output channel (o_out_valid / i_out_ready / o_out_data)
//   returns exactly one result per input: popped value, status, the minimum
//   after the operation and the entry count.
//   One item is worked on at a time. The heap RAM has one write port and two
//   registered read ports; each level of a sift takes a read state and a
//   compare/write state. A push climbs from the new leaf towards the root;
//   a pop moves the last entry to the root and sifts it down, stopping on a
//   leaf or above one. The next input is taken once the result is loaded
//   and the core is back in idle. A push into an empty heap, a full push,
//   an empty pop and a pop of the last entry go straight from idle to the
//   done state.
//   Reset (i_rst_n low, synchronous) empties the heap; the RAM is not
//   cleared since only entries below the count are read.
//   A result waits in the output register while the receiver stalls; the
//   next input is accepted meanwhile and its result holds in the done state.
// -----------------------------------------------------------------------------

module min_heap_priority_queue_core #(
    parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mhpq_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mhpq_pkg::t_out_item o_out_data
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 2;
    localparam int DW = mhpq_pkg::DATA_W;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_UP_RD    = 7'b0000010,
        S_UP_CMP   = 7'b0000100,
        S_POP_LAST = 7'b0001000,
        S_DN_RD    = 7'b0010000,
        S_DN_CMP   = 7'b0100000,
        S_DONE     = 7'b1000000
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_pos, n_pos;
    logic signed [DW-1:0]  r_val, n_val;
    logic signed [DW-1:0]  r_top;
    logic signed [DW-1:0]  r_popped, n_popped;
    logic [1:0]            r_status, n_status;
    logic                  r_right_ok, n_right_ok;
    logic                  r_out_valid;
    mhpq_pkg::t_out_item   r_out;

    logic [DW-1:0]         r_heap_mem [CAPACITY];
    logic signed [DW-1:0]  r_rd_a, r_rd_b;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic signed [DW-1:0]  mem_wdata;
    logic [AW-1:0]         rd_addr_a, rd_addr_b;

    logic                  in_xfer;
    logic                  out_load;
    logic [AW-1:0]         parent;
    logic [XW-1:0]         left_ix, right_ix;
    logic                  left_ok;
    logic                  take_left, take_right;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    assign parent   = AW'((r_pos - AW'(1)) >> 1);
    assign left_ix  = {1'b0, r_pos, 1'b1};
    assign right_ix = left_ix + XW'(1);
    assign left_ok  = left_ix < XW'(r_count);

    // child selection; equal values never move
    assign take_left  = r_rd_a < r_val;
    assign take_right = r_right_ok && (take_left ? (r_rd_b < r_rd_a) : (r_rd_b < r_val));

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_pos      = r_pos;
        n_val      = r_val;
        n_popped   = r_popped;
        n_status   = r_status;
        n_right_ok = r_right_ok;
        mem_we     = 1'b0;
        mem_waddr  = r_pos;
        mem_wdata  = r_val;
        rd_addr_a  = left_ix[AW-1:0];
        rd_addr_b  = right_ix[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_popped = mhpq_pkg::NONE_VALUE;
                    n_status = mhpq_pkg::ST_OK;
                    if (i_in_data.action == mhpq_pkg::ACT_PUSH) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_status = mhpq_pkg::ST_FULL;
                            n_state  = S_DONE;
                        end else if (r_count == '0) begin
                            mem_we    = 1'b1;
                            mem_waddr = '0;
                            mem_wdata = i_in_data.value;
                            n_count   = r_count + CW'(1);
                            n_state   = S_DONE;
                        end else begin
                            n_pos   = AW'(r_count);
                            n_val   = i_in_data.value;
                            n_count = r_count + CW'(1);
                            n_state = S_UP_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = mhpq_pkg::ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_popped  = r_top;
                            n_count   = r_count - CW'(1);
                            rd_addr_a = AW'(r_count - CW'(1));
                            n_state   = (r_count == CW'(1)) ? S_DONE : S_POP_LAST;
                        end
                    end
                end
            end
            S_UP_RD: begin
                if (r_pos == '0) begin
                    mem_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    rd_addr_a = parent;
                    n_state   = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                mem_we = 1'b1;
                if (r_val < r_rd_a) begin
                    // move the parent down into the hole
                    mem_wdata = r_rd_a;
                    n_pos     = parent;
                    n_state   = S_UP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_POP_LAST: begin
                n_val   = r_rd_a;
                n_pos   = '0;
                n_state = S_DN_RD;
            end
            S_DN_RD: begin
                if (!left_ok) begin
                    mem_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_right_ok = right_ix < XW'(r_count);
                    n_state    = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                mem_we = 1'b1;
                if (take_right) begin
                    mem_wdata = r_rd_b;
                    n_pos     = right_ix[AW-1:0];
                    n_state   = S_DN_RD;
                end else if (take_left) begin
                    mem_wdata = r_rd_a;
                    n_pos     = left_ix[AW-1:0];
                    n_state   = S_DN_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // heap RAM: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_heap_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_a <= r_heap_mem[rd_addr_a];
        r_rd_b <= r_heap_mem[rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_val      <= n_val;
        r_popped   <= n_popped;
        r_status   <= n_status;
        r_right_ok <= n_right_ok;
        // shadow of the root entry
        if (mem_we && (mem_waddr == '0)) begin
            r_top <= mem_wdata;
        end
        if (out_load) begin
            r_out.popped_value <= r_popped;
            r_out.status       <= r_status;
            r_out.top_value    <= (r_count == '0) ? mhpq_pkg::NONE_VALUE : r_top;
            r_out.count        <= mhpq_pkg::COUNT_W'(r_count);
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/core/mhpq_checker.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mhpq_checker
// Port-level checks for the min-heap priority queue core.
// -----------------------------------------------------------------------------

module mhpq_checker #(
    parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input mhpq_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input mhpq_pkg::t_out_item o_out_data
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // hold an offered input until it is taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input changed while waiting");

    // an empty pop leaves an empty heap behind
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == mhpq_pkg::ST_EMPTY) |->
            (o_out_data.popped_value == mhpq_pkg::NONE_VALUE) &&
            (o_out_data.top_value == mhpq_pkg::NONE_VALUE) &&
            (o_out_data.count == '0))
        else $error("empty pop reported inconsistent result");

    // a dropped push only happens at capacity
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == mhpq_pkg::ST_FULL) |->
            (o_out_data.popped_value == mhpq_pkg::NONE_VALUE) &&
            (o_out_data.count == mhpq_pkg::COUNT_W'(CAPACITY)))
        else $error("full push reported below capacity");

    // no result right after reset
    a_reset: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind min_heap_priority_queue_core mhpq_checker #(
    .CAPACITY(CAPACITY)
) u_mhpq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
